// ===== rtl/fmr_pkg.sv =====
// fraction max reduce: shared types and constants
`timescale 1ns / 1ps

package fmr_pkg;

    // default datapath word width and the fixed width of every port field
    localparam int WORD_BITS_DEF = 32;
    localparam int PORT_BITS     = 32;

    // operation of the shared step unit
    typedef enum logic
    {
        OP_MUL,
        OP_DIV
    } op_t;

    // sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_PICK,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/fmr_unit.sv =====
// fraction max reduce: shared shift-add / shift-subtract step unit
`timescale 1ns / 1ps

module fmr_unit #(
    parameter int WORD_BITS = fmr_pkg::WORD_BITS_DEF
) (
    input  fmr_pkg::op_t           op,
    input  logic [WORD_BITS:0]     acc,
    input  logic [WORD_BITS-1:0]   low,
    input  logic [WORD_BITS-1:0]   operand,
    output logic [WORD_BITS:0]     acc_next,
    output logic [WORD_BITS-1:0]   low_next
);

    localparam int W = WORD_BITS;

    logic [W:0]   mul_sum;
    logic [W:0]   div_shift;
    logic [W+1:0] div_diff;
    logic         div_ge;

    // multiply step: conditional add, then shift the {acc, low} pair right
    assign mul_sum = {1'b0, acc[W-1:0]} + (low[0] ? {1'b0, operand} : '0);

    // restoring divide step: shift {acc, low} left, trial subtract the divisor
    assign div_shift = {acc[W-1:0], low[W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, operand};
    assign div_ge    = ~div_diff[W+1];

    always_comb
    begin
        case (op)
            fmr_pkg::OP_MUL:
            begin
                acc_next = {1'b0, mul_sum[W:1]};
                low_next = {mul_sum[0], low[W-1:1]};
            end
            fmr_pkg::OP_DIV:
            begin
                acc_next = div_ge ? div_diff[W:0] : div_shift;
                low_next = {low[W-2:0], div_ge};
            end
            default:
            begin
                acc_next = acc;
                low_next = low;
            end
        endcase
    end

endmodule

// ===== rtl/fraction_max_reduce_core.sv =====
// fraction max reduce: top level with sequencer and datapath registers
//
// Takes two signed fractions num_first/den_first and num_second/den_second
// on a valid/ready input channel, picks the larger one (the second on a tie)
// after making both denominators positive, and returns it reduced by the
// gcd of its magnitudes on a valid/ready output channel, together with
// first_won and zero_den_error. Only the low WORD_BITS bits of each input
// are used; num_result and den_result come back zero extended.
// A zero denominator gives a zero result with zero_den_error set.
// Every multiply step, divide step and gcd remainder goes through one shared
// W-bit shift-add / shift-subtract unit, one bit per cycle, so the block
// works on one request at a time and in_ready is high only while idle.
// The result sits in an output register: a new request is taken while it
// waits, and a finished result is held back until the receiver drains it.
// Reset clears the sequencer and the output valid; nothing else needs it.
`timescale 1ns / 1ps

module fraction_max_reduce_core #(
    parameter int WORD_BITS = fmr_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fmr_pkg::PORT_BITS-1:0] num_first,
    input  logic signed [fmr_pkg::PORT_BITS-1:0] den_first,
    input  logic signed [fmr_pkg::PORT_BITS-1:0] num_second,
    input  logic signed [fmr_pkg::PORT_BITS-1:0] den_second,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fmr_pkg::PORT_BITS-1:0] num_result,
    output logic        [fmr_pkg::PORT_BITS-1:0] den_result,
    output logic                                 first_won,
    output logic                                 zero_den_error
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(WORD_BITS);
    localparam int PB = fmr_pkg::PORT_BITS;

    // control registers
    fmr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    logic [W-1:0]    m1_reg, d1_reg, m2_reg, d2_reg;
    logic            s1_reg, s2_reg;
    logic [W:0]      acc_reg;
    logic [W-1:0]    low_reg;
    logic [2*W-1:0]  prod_reg;
    logic [W-1:0]    mag_reg, den_reg, b_reg;
    logic            neg_reg;
    logic [W-1:0]    res_num_reg, res_den_reg;
    logic            first_reg, err_reg;
    logic [W-1:0]    out_num_reg, out_den_reg;
    logic            out_first_reg, out_err_reg;

    // unit connections
    fmr_pkg::op_t    unit_op;
    logic [W-1:0]    unit_operand;
    logic [W:0]      unit_acc;
    logic [W-1:0]    unit_low;

    // input decode
    logic [W-1:0]    in_n1, in_d1, in_n2, in_d2;
    logic [W-1:0]    mag_n1, mag_d1, mag_n2, mag_d2;
    logic            in_s1, in_s2, in_zero_den;
    logic            accept, last, out_free;

    // selection after both products
    logic [2*W-1:0]  p2;
    logic            pick_first;
    logic [W-1:0]    pick_mag, pick_den;
    logic            pick_neg;
    logic [W-1:0]    signed_quot;

    assign accept   = in_valid && in_ready;
    assign last     = (cnt_reg == CW'(W - 1));
    assign out_free = !out_valid_reg || out_ready;

    // low word of each field, magnitude and sign after denominator normalizing
    always_comb
    begin
        in_n1       = num_first[W-1:0];
        in_d1       = den_first[W-1:0];
        in_n2       = num_second[W-1:0];
        in_d2       = den_second[W-1:0];
        mag_n1      = in_n1[W-1] ? W'(-in_n1) : in_n1;
        mag_d1      = in_d1[W-1] ? W'(-in_d1) : in_d1;
        mag_n2      = in_n2[W-1] ? W'(-in_n2) : in_n2;
        mag_d2      = in_d2[W-1] ? W'(-in_d2) : in_d2;
        in_s1       = (in_n1 != '0) && (in_n1[W-1] ^ in_d1[W-1]);
        in_s2       = (in_n2 != '0) && (in_n2[W-1] ^ in_d2[W-1]);
        in_zero_den = (in_d1 == '0) || (in_d2 == '0);
    end

    // compare signed cross products, second wins on a tie
    always_comb
    begin
        p2 = {acc_reg[W-1:0], low_reg};
        if (s1_reg != s2_reg)
        begin
            pick_first = !s1_reg;
        end
        else if (!s1_reg)
        begin
            pick_first = (prod_reg > p2);
        end
        else
        begin
            pick_first = (prod_reg < p2);
        end
        pick_mag = pick_first ? m1_reg : m2_reg;
        pick_den = pick_first ? d1_reg : d2_reg;
        pick_neg = pick_first ? s1_reg : s2_reg;
    end

    // sign the reduced numerator, saturating the one positive overflow
    always_comb
    begin
        if (neg_reg)
        begin
            signed_quot = W'(-unit_low);
        end
        else if (unit_low[W-1])
        begin
            signed_quot = {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            signed_quot = unit_low;
        end
    end

    // shared step unit
    fmr_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .op       (unit_op),
        .acc      (acc_reg),
        .low      (low_reg),
        .operand  (unit_operand),
        .acc_next (unit_acc),
        .low_next (unit_low)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_zero_den ? fmr_pkg::ST_DONE : fmr_pkg::ST_MUL1;
                end
            end
            fmr_pkg::ST_MUL1:
            begin
                if (last)
                begin
                    state_next = fmr_pkg::ST_MUL2;
                end
            end
            fmr_pkg::ST_MUL2:
            begin
                if (last)
                begin
                    state_next = fmr_pkg::ST_PICK;
                end
            end
            fmr_pkg::ST_PICK:
            begin
                state_next = (pick_mag == '0) ? fmr_pkg::ST_DONE : fmr_pkg::ST_GCD;
            end
            fmr_pkg::ST_GCD:
            begin
                if (last && (unit_acc[W-1:0] == '0))
                begin
                    state_next = fmr_pkg::ST_DIVN;
                end
            end
            fmr_pkg::ST_DIVN:
            begin
                if (last)
                begin
                    state_next = fmr_pkg::ST_DIVD;
                end
            end
            fmr_pkg::ST_DIVD:
            begin
                if (last)
                begin
                    state_next = fmr_pkg::ST_DONE;
                end
            end
            fmr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmr_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: unit operation, operand, step count, handshakes
    always_comb
    begin
        in_ready     = (state_reg == fmr_pkg::ST_IDLE);
        unit_op      = fmr_pkg::OP_DIV;
        unit_operand = b_reg;
        cnt_next     = '0;
        case (state_reg)
            fmr_pkg::ST_MUL1:
            begin
                unit_op      = fmr_pkg::OP_MUL;
                unit_operand = m1_reg;
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
            end
            fmr_pkg::ST_MUL2:
            begin
                unit_op      = fmr_pkg::OP_MUL;
                unit_operand = m2_reg;
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
            end
            fmr_pkg::ST_GCD, fmr_pkg::ST_DIVN, fmr_pkg::ST_DIVD:
            begin
                cnt_next = last ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
        if ((state_reg == fmr_pkg::ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmr_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fmr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    m1_reg      <= mag_n1;
                    d1_reg      <= mag_d1;
                    m2_reg      <= mag_n2;
                    d2_reg      <= mag_d2;
                    s1_reg      <= in_s1;
                    s2_reg      <= in_s2;
                    acc_reg     <= '0;
                    low_reg     <= mag_d2;
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    first_reg   <= 1'b0;
                    err_reg     <= in_zero_den;
                end
            end
            fmr_pkg::ST_MUL1:
            begin
                if (last)
                begin
                    prod_reg <= {unit_acc[W-1:0], unit_low};
                    acc_reg  <= '0;
                    low_reg  <= d1_reg;
                end
                else
                begin
                    acc_reg <= unit_acc;
                    low_reg <= unit_low;
                end
            end
            fmr_pkg::ST_MUL2:
            begin
                acc_reg <= unit_acc;
                low_reg <= unit_low;
            end
            fmr_pkg::ST_PICK:
            begin
                first_reg <= pick_first;
                mag_reg   <= pick_mag;
                den_reg   <= pick_den;
                neg_reg   <= pick_neg;
                b_reg     <= pick_den;
                acc_reg   <= '0;
                low_reg   <= pick_mag;
                if (pick_mag == '0)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= W'(1);
                end
            end
            fmr_pkg::ST_GCD:
            begin
                // remainder zero: b holds the gcd, start on the numerator
                if (last)
                begin
                    acc_reg <= '0;
                    if (unit_acc[W-1:0] == '0)
                    begin
                        low_reg <= mag_reg;
                    end
                    else
                    begin
                        b_reg   <= unit_acc[W-1:0];
                        low_reg <= b_reg;
                    end
                end
                else
                begin
                    acc_reg <= unit_acc;
                    low_reg <= unit_low;
                end
            end
            fmr_pkg::ST_DIVN:
            begin
                if (last)
                begin
                    res_num_reg <= signed_quot;
                    acc_reg     <= '0;
                    low_reg     <= den_reg;
                end
                else
                begin
                    acc_reg <= unit_acc;
                    low_reg <= unit_low;
                end
            end
            fmr_pkg::ST_DIVD:
            begin
                acc_reg <= unit_acc;
                low_reg <= unit_low;
                if (last)
                begin
                    res_den_reg <= unit_low;
                end
            end
            fmr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_num_reg   <= res_num_reg;
                    out_den_reg   <= res_den_reg;
                    out_first_reg <= first_reg;
                    out_err_reg   <= err_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign num_result     = $signed(PB'(out_num_reg));
    assign den_result     = PB'(out_den_reg);
    assign first_won      = out_first_reg;
    assign zero_den_error = out_err_reg;

endmodule
